### design/grc_pkg.sv
// Shared types and constants for the grid ray caster.
package grc_pkg;

	localparam int EYE_W    = 20;
	localparam int DIR_W    = 16;
	localparam int DIM_W    = 11;
	localparam int CELL_W   = 4;
	localparam int ROW_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 20;
	localparam int CAM_W    = 28;
	localparam int PROD_W   = 44;
	localparam int RAY_W    = 31;
	localparam int DIVQ_W   = 31;
	localparam int DIVS_W   = 48;
	localparam int DELTA_W  = 41;
	localparam int FRAC_W   = 17;
	localparam int SIDE_W   = 48;
	localparam int FRAC_SH  = 16;
	localparam int DIR_SH   = 14;

	localparam logic [DELTA_W-1:0] FAR_STEP = DELTA_W'(1) << 40;
	localparam logic [DIVQ_W-1:0]  UNIT_Q30 = DIVQ_W'(1) << 30;
	localparam logic signed [CAM_W-1:0] CAM_BIAS = CAM_W'(16384);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_CAST = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_EYE_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EYE_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOK_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOOK_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COLS    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 3'd7;

	typedef enum logic [1:0] {
		DIV_CAM,
		DIV_DX,
		DIV_DY,
		DIV_LH
	} div_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CAM_GO,
		ST_CAM_WAIT,
		ST_RAY_X,
		ST_RAY_Y,
		ST_DX_GO,
		ST_DX_WAIT,
		ST_DY_GO,
		ST_DY_WAIT,
		ST_SIDE_X,
		ST_SIDE_Y,
		ST_WALK_STEP,
		ST_WALK_CHK,
		ST_WALK_TEST,
		ST_LH_GO,
		ST_LH_WAIT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic     grid_wr;
		logic     start_cast;
		logic     div_start;
		logic     div_take;
		div_sel_t div_sel;
		logic     mul_ray;
		logic     side_init;
		logic     axis;
		logic     walk_step;
		logic     walk_test;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic eye_in_grid;
		logic out_of_grid;
		logic wall_hit;
		logic walk_last;
		logic out_free;
	} status_t;

endpackage

### design/grc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module grc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/grc_div.sv
// Restoring divider, one quotient bit per cycle.
module grc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [grc_pkg::DIVQ_W-1:0] dividend,
	input  logic [grc_pkg::DIVS_W-1:0] divisor,
	output logic                       busy,
	output logic [grc_pkg::DIVQ_W-1:0] quotient
);
	import grc_pkg::*;

	localparam int CNT_W = $clog2(DIVQ_W + 1);

	logic [DIVS_W:0]   rem_q;
	logic [DIVQ_W-1:0] quo_q;
	logic [DIVS_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [DIVS_W:0]   trial;
	logic              ge;

	assign trial = {rem_q[DIVS_W-1:0], quo_q[DIVQ_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIVQ_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[DIVQ_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

### design/grc_dpath.sv
// Datapath: configuration, grid store, ray setup, DDA walk and strip output.
module grc_dpath #(
	parameter int GRID_SIZE  = 16,
	parameter int SCREEN_MAX = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [grc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [grc_pkg::CFG_W-1:0]     wr_data,
	input  logic [grc_pkg::DIM_W-1:0]     column,
	input  logic [grc_pkg::CELL_W-1:0]    row_index,
	input  logic [grc_pkg::ROW_W-1:0]     row_cells,
	input  grc_pkg::cmd_t                 cmd,
	output grc_pkg::status_t              status,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [grc_pkg::DIM_W-1:0]     strip_column,
	output logic [grc_pkg::DIM_W-1:0]     draw_top,
	output logic [grc_pkg::DIM_W-1:0]     draw_bottom,
	output logic                          hit_side,
	output logic [grc_pkg::CELL_W-1:0]    wall_cell_x,
	output logic [grc_pkg::CELL_W-1:0]    wall_cell_y,
	output logic                          wall_found
);
	import grc_pkg::*;

	localparam int AW  = $clog2(GRID_SIZE);
	localparam int GW  = AW + 2;
	localparam int NW  = $clog2(2 * GRID_SIZE + 3);
	localparam int CAP = 2 * SCREEN_MAX;
	localparam int LW  = $clog2(CAP) + 1;
	localparam int CW  = ((LW > DIM_W) ? LW : DIM_W) + 1;

	logic [EYE_W-1:0]        eye_x_q, eye_y_q;
	logic signed [DIR_W-1:0] look_x_q, look_y_q, plane_dx_q, plane_dy_q;
	logic [DIM_W-1:0]        cols_q, rows_q, cols_eff, rows_eff;

	logic [DIM_W-1:0]         col_q;
	logic signed [CAM_W-1:0]  cam_q;
	logic signed [RAY_W-1:0]  ray_x_q, ray_y_q;
	logic [DELTA_W-1:0]       dx_q, dy_q;
	logic [SIDE_W-1:0]        sdx_q, sdy_q, perp_q;
	logic signed [GW-1:0]     mx_q, my_q;
	logic [NW-1:0]            n_q;
	logic                     side_q, found_q, inside_q;
	logic [LW-1:0]            lh_q;
	logic [GRID_SIZE-1:0]     valid_q;

	logic                     out_valid_q;
	logic [DIM_W-1:0]         col_o_q, top_o_q, bot_o_q;
	logic                     side_o_q, found_o_q;
	logic [CELL_W-1:0]        cx_o_q, cy_o_q;

	logic                     div_busy;
	logic [DIVQ_W-1:0]        div_dvd, div_quo;
	logic [DIVS_W-1:0]        div_dvs;

	logic signed [DIR_W-1:0]  pl_sel, lk_sel;
	logic signed [PROD_W-1:0] prod_ray;
	logic signed [RAY_W-1:0]  ray_new, ray_sel;
	logic [RAY_W-1:0]         mag_x, mag_y;
	logic [FRAC_W-1:0]        frac_sel;
	logic [EYE_W-1:0]         eye_sel;
	logic [DELTA_W-1:0]       delta_sel;
	logic [SIDE_W-1:0]        prod_side, side_new;
	logic                     x_first;
	logic [AW-1:0]            gw_addr;
	logic [GRID_SIZE+ROW_W-1:0] cells_ext;
	logic [GRID_SIZE-1:0]     rd_row;
	logic                     gw_ok;
	logic [CW-1:0]            half_l, half_r, rows_c, bot_sum;
	logic [DIM_W-1:0]         top_v, bot_v;

	// configuration
	assign cols_eff = (cols_q == '0) ? DIM_W'(1) : cols_q;
	assign rows_eff = (rows_q == '0) ? DIM_W'(1) : rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q    <= EYE_W'(458752);
			eye_y_q    <= EYE_W'(524288);
			look_x_q   <= -DIR_W'(16384);
			look_y_q   <= '0;
			plane_dx_q <= '0;
			plane_dy_q <= DIR_W'(10813);
			cols_q     <= DIM_W'(640);
			rows_q     <= DIM_W'(480);
		end else if (wr_en) begin
			case (wr_index)
				REG_EYE_X:   eye_x_q    <= wr_data;
				REG_EYE_Y:   eye_y_q    <= wr_data;
				REG_LOOK_X:  look_x_q   <= wr_data[DIR_W-1:0];
				REG_LOOK_Y:  look_y_q   <= wr_data[DIR_W-1:0];
				REG_PLANE_X: plane_dx_q <= wr_data[DIR_W-1:0];
				REG_PLANE_Y: plane_dy_q <= wr_data[DIR_W-1:0];
				REG_COLS:    cols_q     <= wr_data[DIM_W-1:0];
				REG_ROWS:    rows_q     <= wr_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// grid store
	assign gw_ok     = 32'(row_index) < 32'(GRID_SIZE);
	assign gw_addr   = AW'(row_index);
	assign cells_ext = {{GRID_SIZE{1'b0}}, row_cells};

	grc_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_grid (
		.clk   (clk),
		.we    (cmd.grid_wr && gw_ok),
		.waddr (gw_addr),
		.wdata (cells_ext[GRID_SIZE-1:0]),
		.raddr (mx_q[AW-1:0]),
		.rdata (rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.grid_wr && gw_ok) begin
			valid_q[gw_addr] <= 1'b1;
		end
	end

	// shared divider
	assign mag_x = ray_x_q[RAY_W-1] ? RAY_W'(-ray_x_q) : RAY_W'(ray_x_q);
	assign mag_y = ray_y_q[RAY_W-1] ? RAY_W'(-ray_y_q) : RAY_W'(ray_y_q);

	always_comb begin
		case (cmd.div_sel)
			DIV_CAM: begin
				div_dvd = DIVQ_W'({col_q, 15'b0});
				div_dvs = DIVS_W'(cols_eff);
			end
			DIV_DX: begin
				div_dvd = UNIT_Q30;
				div_dvs = DIVS_W'(mag_x);
			end
			DIV_DY: begin
				div_dvd = UNIT_Q30;
				div_dvs = DIVS_W'(mag_y);
			end
			DIV_LH: begin
				div_dvd = DIVQ_W'({rows_eff, 16'b0});
				div_dvs = perp_q;
			end
			default: begin
				div_dvd = '0;
				div_dvs = '0;
			end
		endcase
	end

	grc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// ray and first side distances
	assign pl_sel   = cmd.axis ? plane_dy_q : plane_dx_q;
	assign lk_sel   = cmd.axis ? look_y_q : look_x_q;
	assign prod_ray = PROD_W'(pl_sel) * PROD_W'(cam_q);
	assign ray_new  = RAY_W'(lk_sel) + RAY_W'(prod_ray >>> DIR_SH);

	assign ray_sel   = cmd.axis ? ray_y_q : ray_x_q;
	assign eye_sel   = cmd.axis ? eye_y_q : eye_x_q;
	assign delta_sel = cmd.axis ? dy_q : dx_q;
	assign frac_sel  = ray_sel[RAY_W-1] ? {1'b0, eye_sel[FRAC_SH-1:0]}
	                                    : FRAC_W'(65536) - {1'b0, eye_sel[FRAC_SH-1:0]};
	assign prod_side = SIDE_W'(frac_sel) * SIDE_W'(delta_sel[DIVQ_W-1:0]);
	assign side_new  = (delta_sel == FAR_STEP) ? SIDE_W'({frac_sel, 24'b0})
	                                           : (prod_side >> FRAC_SH);

	assign x_first = sdx_q < sdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			n_q     <= '0;
		end else if (cmd.start_cast) begin
			found_q <= 1'b0;
			n_q     <= '0;
		end else begin
			if (cmd.walk_step) begin
				n_q <= n_q + NW'(1);
			end
			if (cmd.walk_test) begin
				found_q <= status.wall_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_cast) begin
			col_q    <= column;
			side_q   <= 1'b0;
			inside_q <= (32'(eye_x_q[EYE_W-1:FRAC_SH]) < 32'(GRID_SIZE))
			         && (32'(eye_y_q[EYE_W-1:FRAC_SH]) < 32'(GRID_SIZE));
			mx_q     <= GW'(eye_x_q[EYE_W-1:FRAC_SH]);
			my_q     <= GW'(eye_y_q[EYE_W-1:FRAC_SH]);
		end
		if (cmd.div_take) begin
			case (cmd.div_sel)
				DIV_CAM: cam_q <= $signed({1'b0, div_quo[CAM_W-2:0]}) - CAM_BIAS;
				DIV_DX:  dx_q  <= (mag_x == '0) ? FAR_STEP : DELTA_W'(div_quo);
				DIV_DY:  dy_q  <= (mag_y == '0) ? FAR_STEP : DELTA_W'(div_quo);
				DIV_LH:  lh_q  <= (div_quo < DIVQ_W'(CAP)) ? LW'(div_quo) : LW'(CAP);
				default: ;
			endcase
		end
		if (cmd.mul_ray) begin
			if (cmd.axis) begin
				ray_y_q <= ray_new;
			end else begin
				ray_x_q <= ray_new;
			end
		end
		if (cmd.side_init) begin
			if (cmd.axis) begin
				sdy_q <= side_new;
			end else begin
				sdx_q <= side_new;
			end
		end
		if (cmd.walk_step) begin
			if (x_first) begin
				perp_q <= sdx_q;
				sdx_q  <= sdx_q + SIDE_W'(dx_q);
				mx_q   <= ray_x_q[RAY_W-1] ? mx_q - GW'(1) : mx_q + GW'(1);
				side_q <= 1'b0;
			end else begin
				perp_q <= sdy_q;
				sdy_q  <= sdy_q + SIDE_W'(dy_q);
				my_q   <= ray_y_q[RAY_W-1] ? my_q - GW'(1) : my_q + GW'(1);
				side_q <= 1'b1;
			end
		end
	end

	// strip bounds
	assign half_l  = CW'(lh_q >> 1);
	assign half_r  = CW'(rows_eff >> 1);
	assign rows_c  = CW'(rows_eff);
	assign bot_sum = half_l + half_r;
	assign top_v   = (half_r > half_l) ? DIM_W'(half_r - half_l) : '0;
	assign bot_v   = (bot_sum >= rows_c) ? DIM_W'(rows_c - CW'(1)) : DIM_W'(bot_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			col_o_q   <= col_q;
			found_o_q <= found_q;
			top_o_q   <= found_q ? top_v : '0;
			bot_o_q   <= found_q ? bot_v : '0;
			side_o_q  <= found_q & side_q;
			cx_o_q    <= found_q ? CELL_W'(mx_q) : '0;
			cy_o_q    <= found_q ? CELL_W'(my_q) : '0;
		end
	end

	assign status.div_busy    = div_busy;
	assign status.eye_in_grid = inside_q;
	assign status.out_of_grid = mx_q[GW-1] || ($unsigned(mx_q) >= GW'(GRID_SIZE))
	                         || my_q[GW-1] || ($unsigned(my_q) >= GW'(GRID_SIZE));
	assign status.wall_hit    = rd_row[my_q[AW-1:0]] & valid_q[mx_q[AW-1:0]];
	assign status.walk_last   = n_q == NW'(2 * GRID_SIZE + 2);
	assign status.out_free    = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign strip_column = col_o_q;
	assign draw_top     = top_o_q;
	assign draw_bottom  = bot_o_q;
	assign hit_side     = side_o_q;
	assign wall_cell_x  = cx_o_q;
	assign wall_cell_y  = cy_o_q;
	assign wall_found   = found_o_q;

endmodule

### design/grc_ctrl.sv
// Controller: sequences the ray setup, the DDA walk and the strip result.
module grc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             command,
	input  grc_pkg::status_t status,
	output grc_pkg::cmd_t    cmd,
	output logic             in_stall
);
	import grc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (command == CMD_LOAD) begin
						cmd.grid_wr = 1'b1;
					end else begin
						cmd.start_cast = 1'b1;
						state_d        = ST_CAM_GO;
					end
				end
			end
			ST_CAM_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_CAM;
				state_d       = ST_CAM_WAIT;
			end
			ST_CAM_WAIT: begin
				cmd.div_sel = DIV_CAM;
				if (!status.div_busy) begin
					cmd.div_take = 1'b1;
					state_d      = ST_RAY_X;
				end
			end
			ST_RAY_X: begin
				cmd.mul_ray = 1'b1;
				state_d     = ST_RAY_Y;
			end
			ST_RAY_Y: begin
				cmd.mul_ray = 1'b1;
				cmd.axis    = 1'b1;
				state_d     = ST_DX_GO;
			end
			ST_DX_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_DX;
				state_d       = ST_DX_WAIT;
			end
			ST_DX_WAIT: begin
				cmd.div_sel = DIV_DX;
				if (!status.div_busy) begin
					cmd.div_take = 1'b1;
					state_d      = ST_DY_GO;
				end
			end
			ST_DY_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_DY;
				state_d       = ST_DY_WAIT;
			end
			ST_DY_WAIT: begin
				cmd.div_sel = DIV_DY;
				if (!status.div_busy) begin
					cmd.div_take = 1'b1;
					state_d      = ST_SIDE_X;
				end
			end
			ST_SIDE_X: begin
				cmd.side_init = 1'b1;
				state_d       = ST_SIDE_Y;
			end
			ST_SIDE_Y: begin
				cmd.side_init = 1'b1;
				cmd.axis      = 1'b1;
				state_d       = status.eye_in_grid ? ST_WALK_STEP : ST_RESULT;
			end
			ST_WALK_STEP: begin
				cmd.walk_step = 1'b1;
				state_d       = ST_WALK_CHK;
			end
			ST_WALK_CHK: begin
				state_d = status.out_of_grid ? ST_RESULT : ST_WALK_TEST;
			end
			ST_WALK_TEST: begin
				cmd.walk_test = 1'b1;
				if (status.wall_hit) begin
					state_d = ST_LH_GO;
				end else if (status.walk_last) begin
					state_d = ST_RESULT;
				end else begin
					state_d = ST_WALK_STEP;
				end
			end
			ST_LH_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_LH;
				state_d       = ST_LH_WAIT;
			end
			ST_LH_WAIT: begin
				cmd.div_sel = DIV_LH;
				if (!status.div_busy) begin
					cmd.div_take = 1'b1;
					state_d      = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### design/grid_ray_cast_column.sv
// Grid DDA ray caster: one wall strip per screen column.
// A load word writes one grid row in the cycle it is accepted.
// A cast word runs the DDA walk and four passes of the shared one-bit-per-cycle divider on a hit,
// three on a miss, and may also wait on output stalls.
// One word is worked on at a time; the result register frees the output side.
// Reset restores the default camera and clears the grid to no walls.
module grid_ray_cast_column #(
	parameter int GRID_SIZE  = 16,
	parameter int SCREEN_MAX = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [grc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [grc_pkg::CFG_W-1:0]     wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [grc_pkg::DIM_W-1:0]     column,
	input  logic [grc_pkg::CELL_W-1:0]    row_index,
	input  logic [grc_pkg::ROW_W-1:0]     row_cells,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [grc_pkg::DIM_W-1:0]     strip_column,
	output logic [grc_pkg::DIM_W-1:0]     draw_top,
	output logic [grc_pkg::DIM_W-1:0]     draw_bottom,
	output logic                          hit_side,
	output logic [grc_pkg::CELL_W-1:0]    wall_cell_x,
	output logic [grc_pkg::CELL_W-1:0]    wall_cell_y,
	output logic                          wall_found
);
	import grc_pkg::*;

	cmd_t    cmd;
	status_t status;

	grc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	grc_dpath #(.GRID_SIZE(GRID_SIZE), .SCREEN_MAX(SCREEN_MAX)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.column       (column),
		.row_index    (row_index),
		.row_cells    (row_cells),
		.cmd          (cmd),
		.status       (status),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.strip_column (strip_column),
		.draw_top     (draw_top),
		.draw_bottom  (draw_bottom),
		.hit_side     (hit_side),
		.wall_cell_x  (wall_cell_x),
		.wall_cell_y  (wall_cell_y),
		.wall_found   (wall_found)
	);

	a_cast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == CMD_CAST) |=> in_stall)
		else $error("cast word did not hold off input");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !wall_found |-> (draw_top == '0) && (draw_bottom == '0)
		&& !hit_side)
		else $error("miss word carries nonzero strip");

	a_strip_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wall_found |-> draw_top <= draw_bottom)
		else $error("strip top below bottom");

endmodule
